// ===== src/dtp_pkg.sv =====
// shared types and codes for the der tlv header parser
package dtp_pkg;

  // result status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StTrunc   = 2'd1;
  localparam logic [1:0] StBadForm = 2'd2;
  localparam logic [1:0] StTooWide = 2'd3;

  // length form constants
  localparam logic [7:0] LongFormBit  = 8'h80;
  localparam logic [6:0] CountMask    = 7'h7F;
  localparam logic [6:0] MaxLenBytes  = 7'd8;

  // one result item
  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [7:0]  tag_byte;
    logic [31:0] value_length;
    logic [31:0] value_offset;
    logic        buffer_end;
  } result_t;

endpackage

// ===== src/dtp_core.sv =====
// parser state and per-byte next-state and result logic
module dtp_core #(
  parameter int LEN_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_i,
  output dtp_pkg::result_t res_o
);

  // parser phases
  localparam logic [2:0] PhTag      = 3'd0;
  localparam logic [2:0] PhLenFirst = 3'd1;
  localparam logic [2:0] PhLenMore  = 3'd2;
  localparam logic [2:0] PhValue    = 3'd3;
  localparam logic [2:0] PhSkip     = 3'd4;

  logic [2:0]          phase_q, phase_d;
  logic [7:0]          tag_q, tag_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic [3:0]          lbl_q, lbl_d;
  logic [LEN_BITS-1:0] vbl_q, vbl_d;
  logic [31:0]         pos_q, pos_d;
  logic [31:0]         vstart_q, vstart_d;

  logic                have_len;
  logic [LEN_BITS-1:0] len;
  logic [LEN_BITS-1:0] vbl_dec;
  logic [LEN_BITS-1:0] acc_shift;
  logic [3:0]          lbl_dec;
  logic [31:0]         pos_inc;
  logic [63:0]         acc_wide;
  logic [6:0]          count;

  assign vbl_dec   = vbl_q - LEN_BITS'(1);
  assign acc_shift = (acc_q << 8) | LEN_BITS'(data_byte_i);
  assign lbl_dec   = lbl_q - 4'd1;
  assign pos_inc   = pos_q + 32'd1;
  assign count     = data_byte_i[6:0] & dtp_pkg::CountMask;

  // next state and result for the byte in the input register
  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    acc_d    = acc_q;
    lbl_d    = lbl_q;
    vbl_d    = vbl_q;
    vstart_d = vstart_q;
    pos_d    = pos_inc;
    have_len = 1'b0;
    len      = '0;
    acc_wide = 64'(acc_q);
    res_o    = '0;
    res_o.buffer_end = last_i;

    unique case (phase_q)
      PhTag: begin
        tag_d   = data_byte_i;
        phase_d = PhLenFirst;
      end
      PhLenFirst: begin
        if ((data_byte_i & dtp_pkg::LongFormBit) == 8'd0) begin
          len      = LEN_BITS'(data_byte_i);
          have_len = 1'b1;
        end else if (count == 7'd0 || count > dtp_pkg::MaxLenBytes) begin
          res_o.valid    = 1'b1;
          res_o.status   = dtp_pkg::StBadForm;
          res_o.tag_byte = tag_q;
          phase_d        = PhSkip;
        end else begin
          lbl_d   = count[3:0];
          acc_d   = '0;
          phase_d = PhLenMore;
        end
      end
      PhLenMore: begin
        if (acc_q[LEN_BITS-1 -: 8] != 8'd0) begin
          res_o.valid    = 1'b1;
          res_o.status   = dtp_pkg::StTooWide;
          res_o.tag_byte = tag_q;
          phase_d        = PhSkip;
        end else begin
          acc_d = acc_shift;
          lbl_d = lbl_dec;
          if (lbl_dec == 4'd0) begin
            len      = acc_shift;
            have_len = 1'b1;
          end
        end
      end
      PhValue: begin
        vbl_d = vbl_dec;
        if (vbl_dec == '0) begin
          res_o.valid        = 1'b1;
          res_o.status       = dtp_pkg::StOk;
          res_o.tag_byte     = tag_q;
          res_o.value_length = acc_wide[31:0];
          res_o.value_offset = vstart_q;
          phase_d            = PhTag;
        end
      end
      default: begin
      end
    endcase

    // length known: zero length completes at once
    if (have_len) begin
      acc_d    = len;
      vstart_d = pos_inc;
      acc_wide = 64'(len);
      if (len == '0) begin
        res_o.valid        = 1'b1;
        res_o.status       = dtp_pkg::StOk;
        res_o.tag_byte     = tag_q;
        res_o.value_length = 32'd0;
        res_o.value_offset = pos_inc;
        phase_d            = PhTag;
      end else begin
        vbl_d   = len;
        phase_d = PhValue;
      end
    end

    // buffer end: truncation report unless already reported or skipping, and parser reset
    if (last_i) begin
      if (!res_o.valid && phase_q != PhSkip) begin
        res_o.valid        = 1'b1;
        res_o.status       = dtp_pkg::StTrunc;
        res_o.tag_byte     = tag_d;
        res_o.value_length = 32'd0;
        res_o.value_offset = 32'd0;
      end
      phase_d  = PhTag;
      tag_d    = '0;
      acc_d    = '0;
      lbl_d    = '0;
      vbl_d    = '0;
      pos_d    = '0;
      vstart_d = '0;
    end

    if (!fire_i) begin
      res_o.valid = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhTag;
      tag_q    <= '0;
      acc_q    <= '0;
      lbl_q    <= '0;
      vbl_q    <= '0;
      pos_q    <= '0;
      vstart_q <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      tag_q    <= tag_d;
      acc_q    <= acc_d;
      lbl_q    <= lbl_d;
      vbl_q    <= vbl_d;
      pos_q    <= pos_d;
      vstart_q <= vstart_d;
    end
  end

  // skipping after an error never reports
  a_skip_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && phase_q == PhSkip) |-> !res_o.valid)
    else $error("result while skipping");

  // buffer end always returns to tag phase with position cleared
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && last_i) |=> (phase_q == PhTag && pos_q == 32'd0))
    else $error("buffer end did not reset parser");

  // value phase always has bytes left to count
  a_value_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhValue) |-> (vbl_q != '0))
    else $error("value phase with zero count");

endmodule

// ===== src/der_tlv_header_parser_top.sv =====
// top level of the der tlv header parser: input register, core, result register
//
//  channel | valid / ready         | payload
//  in      | in_valid_i / in_ready_o  | data_byte_i, last_of_buffer_i
//  out     | out_valid_o / out_ready_i | status_o, tag_byte_o, value_length_o,
//          |                       | value_offset_o, buffer_end_o
//
// one byte per cycle sustained while the result side does not stall; a byte's result
// passes the input register, then the core's single-pass logic into the result register
// reset clears the parser phase, counters and both valid flags at once
// a stalled result holds the result register; the input register then fills and
// in_ready_o drops until the result is taken
module der_tlv_header_parser_top #(
  parameter int LEN_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  tag_byte_o,
  output logic [31:0] value_length_o,
  output logic [31:0] value_offset_o,
  output logic        buffer_end_o
);

  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             advance;
  logic             fire;
  dtp_pkg::result_t res;
  dtp_pkg::result_t out_q;

  // handshake control
  assign advance    = !out_q.valid || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
      last_q <= last_of_buffer_i;
    end
  end

  dtp_core #(
    .LEN_BITS(LEN_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .data_byte_i(byte_q),
    .last_i     (last_q),
    .res_o      (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_q.valid;
  assign status_o       = out_q.status;
  assign tag_byte_o     = out_q.tag_byte;
  assign value_length_o = out_q.value_length;
  assign value_offset_o = out_q.value_offset;
  assign buffer_end_o   = out_q.buffer_end;

endmodule

// ===== tb/tb_der_tlv_header_parser_top.sv =====
// testbench for the der tlv header parser: byte stream stimulus, parse prediction, result check
`timescale 1ns / 1ps

module tb_der_tlv_header_parser_top;

  localparam int LenBits = 32;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomBytes = 1450;
  localparam int unsigned HoldStart = 1200;
  localparam int unsigned HoldCycles = 300;

  // parser phases of the prediction
  typedef enum logic [2:0] {
    PhTag,
    PhLenFirst,
    PhLenMore,
    PhValue,
    PhSkip
  } parse_phase_e;

  // one buffer byte waiting to be sent
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } buf_byte_t;

  // one element report
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  tag;
    logic [31:0] len;
    logic [31:0] off;
    logic        last;
  } tlv_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_of_buffer_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  tag_byte_o;
  logic [31:0] value_length_o;
  logic [31:0] value_offset_o;
  logic        buffer_end_o;

  buf_byte_t   byte_q[$];
  tlv_report_t report_q[$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          drain_next = 1'b0;

  // predicted parser state
  parse_phase_e pr_phase = PhTag;
  logic [7:0]   pr_tag = 8'h00;
  logic [63:0]  pr_len_acc = '0;
  logic [3:0]   pr_len_left = '0;
  logic [63:0]  pr_value_left = '0;
  logic [31:0]  pr_pos = '0;
  logic [31:0]  pr_value_start = '0;

  always #5 clk_i = ~clk_i;

  der_tlv_header_parser_top #(
    .LEN_BITS(LenBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_of_buffer_i(last_of_buffer_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .tag_byte_o      (tag_byte_o),
    .value_length_o  (value_length_o),
    .value_offset_o  (value_offset_o),
    .buffer_end_o    (buffer_end_o)
  );

  // advance the predicted parser by one byte and queue the report it causes
  function automatic void parse_byte(input logic [7:0] b, input logic lst);
    tlv_report_t  rep;
    bit           has_rep;
    bit           has_len;
    logic [63:0]  len;
    logic [31:0]  pos;
    logic [6:0]   cnt;
    parse_phase_e entry;
    rep = '0;
    has_rep = 1'b0;
    has_len = 1'b0;
    len = '0;
    pos = pr_pos;
    entry = pr_phase;
    cnt = b[6:0] & dtp_pkg::CountMask;
    case (entry)
      PhTag: begin
        pr_tag = b;
        pr_phase = PhLenFirst;
      end
      PhLenFirst: begin
        if (b < dtp_pkg::LongFormBit) begin
          len = {56'd0, b};
          has_len = 1'b1;
        end else if (cnt == 7'd0 || cnt > dtp_pkg::MaxLenBytes) begin
          // indefinite form or too many length bytes
          rep = '{dtp_pkg::StBadForm, pr_tag, 32'd0, 32'd0, lst};
          has_rep = 1'b1;
          pr_phase = PhSkip;
        end else begin
          pr_len_left = cnt[3:0];
          pr_len_acc = '0;
          pr_phase = PhLenMore;
        end
      end
      PhLenMore: begin
        if ((pr_len_acc >> (LenBits - 8)) != 64'd0) begin
          rep = '{dtp_pkg::StTooWide, pr_tag, 32'd0, 32'd0, lst};
          has_rep = 1'b1;
          pr_phase = PhSkip;
        end else begin
          pr_len_acc = (pr_len_acc << 8) | {56'd0, b};
          pr_len_left = pr_len_left - 4'd1;
          if (pr_len_left == 4'd0) begin
            len = pr_len_acc;
            has_len = 1'b1;
          end
        end
      end
      PhValue: begin
        pr_value_left = pr_value_left - 64'd1;
        if (pr_value_left == 64'd0) begin
          rep = '{dtp_pkg::StOk, pr_tag, pr_len_acc[31:0], pr_value_start, lst};
          has_rep = 1'b1;
          pr_phase = PhTag;
        end
      end
      default: ;
    endcase

    // length known: zero length completes at once
    if (has_len) begin
      pr_len_acc = len;
      pr_value_start = pos + 32'd1;
      if (len == 64'd0) begin
        rep = '{dtp_pkg::StOk, pr_tag, 32'd0, pr_value_start, lst};
        has_rep = 1'b1;
        pr_phase = PhTag;
      end else begin
        pr_value_left = len;
        pr_phase = PhValue;
      end
    end

    pr_pos = pos + 32'd1;

    // buffer end: truncation report unless already reported or skipping
    if (lst) begin
      if (!has_rep && entry != PhSkip) begin
        rep = '{dtp_pkg::StTrunc, pr_tag, 32'd0, 32'd0, 1'b1};
        has_rep = 1'b1;
      end
      pr_phase = PhTag;
      pr_tag = 8'h00;
      pr_len_acc = '0;
      pr_len_left = '0;
      pr_value_left = '0;
      pr_pos = '0;
      pr_value_start = '0;
    end

    if (has_rep) report_q.push_back(rep);
  endfunction

  // idle length: mostly none or short, a few long, with idle-free stretches
  function automatic int unsigned pick_gap(ref int unsigned calm_left);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (r < 2) begin
      calm_left = $urandom_range(40, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // stimulus queue helpers
  task automatic push_byte(input logic [7:0] b);
    byte_q.push_back('{b, 1'b0, drain_next});
    drain_next = 1'b0;
  endtask

  task automatic close_buffer();
    buf_byte_t tail;
    tail = byte_q.pop_back();
    tail.last = 1'b1;
    byte_q.push_back(tail);
  endtask

  // one well-formed element; nlen zero means short form
  task automatic add_element(input logic [7:0] tag, input int unsigned len,
                             input int unsigned nlen);
    logic [63:0] lenv;
    lenv = 64'(len);
    push_byte(tag);
    if (nlen == 0) begin
      push_byte(lenv[7:0]);
    end else begin
      push_byte(dtp_pkg::LongFormBit | 8'(nlen));
      for (int i = int'(nlen) - 1; i >= 0; i--) push_byte(lenv[8*i +: 8]);
    end
    repeat (len) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_random_element();
    int unsigned r;
    int unsigned len;
    int unsigned nlen;
    r = $urandom_range(0, 99);
    if (r < 50) len = $urandom_range(0, 6);
    else if (r < 85) len = $urandom_range(7, 24);
    else if (r < 97) len = $urandom_range(25, 80);
    else len = $urandom_range(81, 300);
    if (len > 255) nlen = $urandom_range(2, 8);
    else if (len > 127) nlen = $urandom_range(1, 8);
    else if ($urandom_range(0, 9) < 6) nlen = 0;
    else nlen = $urandom_range(1, 8);
    add_element(8'($urandom_range(0, 255)), len, nlen);
  endtask

  // element with a broken length form, followed by ignored bytes
  task automatic add_bad_element();
    int unsigned n;
    push_byte(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 2))
      0: push_byte(dtp_pkg::LongFormBit);
      1: push_byte(8'($urandom_range(8'h89, 8'hFF)));
      default: begin
        // wider than the length register: nonzero leading byte, five or more bytes
        n = $urandom_range(5, 8);
        push_byte(dtp_pkg::LongFormBit | 8'(n));
        push_byte(8'($urandom_range(1, 255)));
        repeat (n - 1) push_byte(8'($urandom_range(0, 255)));
      end
    endcase
    repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
  endtask

  // element cut short by the buffer end
  task automatic add_partial_element();
    int unsigned len;
    push_byte(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 3))
      0: ;
      1: push_byte(dtp_pkg::LongFormBit | 8'($urandom_range(1, 8)));
      2: begin
        push_byte(8'h82);
        push_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        len = $urandom_range(1, 40);
        push_byte(8'(len));
        repeat ($urandom_range(0, len - 1)) push_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic add_random_buffer();
    int unsigned r;
    if ($urandom_range(0, 99) < 6) drain_next = 1'b1;
    repeat ($urandom_range(1, 5)) add_random_element();
    r = $urandom_range(0, 99);
    if (r >= 85) add_partial_element();
    else if (r >= 65) add_bad_element();
    close_buffer();
  endtask

  // directed buffers, bit 8 marks the final byte
  localparam logic [8:0] DirectedSeq [24] = '{
    // zero length, two-byte value, one-byte long form ending the buffer
    9'h000, 9'h000, 9'h0FF, 9'h002, 9'h0AA, 9'h0BB, 9'h031, 9'h081, 9'h001, 9'h1CC,
    // indefinite form, ignored bytes up to the end
    9'h004, 9'h080, 9'h055, 9'h100,
    // too many length bytes on the final byte
    9'h002, 9'h189,
    // buffer ending right after the tag
    9'h1A5,
    // length too wide, hit on the final byte
    9'h005, 9'h085, 9'h001, 9'h000, 9'h000, 9'h000, 9'h107
  };

  // stimulus and end of run
  initial begin
    foreach (DirectedSeq[i]) byte_q.push_back('{DirectedSeq[i][7:0], DirectedSeq[i][8], 1'b0});
    // first random buffer waits until the directed part has drained
    drain_next = 1'b1;
    while (byte_q.size() < RandomBytes + $size(DirectedSeq)) add_random_buffer();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // driver: offer queued bytes, predict on each transfer
  int unsigned tx_gap = 0;
  int unsigned tx_calm = 0;
  logic        tx_valid_nxt;
  buf_byte_t   tx_cur;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      data_byte_i <= 8'h00;
      last_of_buffer_i <= 1'b0;
    end else begin
      tx_valid_nxt = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        parse_byte(data_byte_i, last_of_buffer_i);
        tx_valid_nxt = 1'b0;
      end
      if (!tx_valid_nxt) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (byte_q.size() != 0 && !(byte_q[0].drain && report_q.size() != 0)) begin
          tx_cur = byte_q.pop_front();
          data_byte_i <= tx_cur.data;
          last_of_buffer_i <= tx_cur.last;
          tx_valid_nxt = 1'b1;
          tx_gap = pick_gap(tx_calm);
        end
      end
      in_valid_i <= tx_valid_nxt;
    end
  end

  // receiver: random stalls plus one long hold-off
  int unsigned rx_cycles = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_run = 0;
  int unsigned rx_calm = 0;
  logic        rx_ready_nxt;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      rx_cycles++;
      rx_ready_nxt = out_ready_i;
      if (rx_cycles == HoldStart) rx_hold = HoldCycles;
      if (rx_hold > 0) begin
        rx_hold--;
        rx_ready_nxt = 1'b0;
        rx_run = 0;
      end else if (rx_run > 0) begin
        rx_run--;
      end else if (!out_ready_i) begin
        rx_ready_nxt = 1'b1;
        rx_run = $urandom_range(1, 20);
      end else begin
        rx_run = pick_gap(rx_calm);
        rx_ready_nxt = (rx_run == 0);
      end
      out_ready_i <= rx_ready_nxt;
    end
  end

  // compare one report field
  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  // monitor: each result transfer against the oldest prediction
  tlv_report_t mon_want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0d tag %0h",
                 $time, status_o, tag_byte_o);
        fail_cnt++;
      end else begin
        mon_want = report_q.pop_front();
        check_field("status", 32'(mon_want.status), 32'(status_o));
        check_field("tag_byte", 32'(mon_want.tag), 32'(tag_byte_o));
        check_field("value_length", mon_want.len, value_length_o);
        check_field("value_offset", mon_want.off, value_offset_o);
        check_field("buffer_end", 32'(mon_want.last), 32'(buffer_end_o));
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

// ===== files.f =====
src/dtp_pkg.sv
src/dtp_core.sv
src/der_tlv_header_parser_top.sv
tb/tb_der_tlv_header_parser_top.sv
